FILE: design/tkd_pkg.sv
package tkd_pkg;

    localparam int LimitWidth = 20;
    localparam int CodeWidth  = 5;
    localparam int ByteWidth  = 8;
    localparam int DigitWidth = 3;

    localparam logic [LimitWidth-1:0] LimitReset = 20'd100000;

    // key codes, densely numbered
    localparam logic [CodeWidth-1:0] KEY_PRINT   = 5'd0;
    localparam logic [CodeWidth-1:0] KEY_ENTER   = 5'd1;
    localparam logic [CodeWidth-1:0] KEY_ESC     = 5'd2;
    localparam logic [CodeWidth-1:0] KEY_UP      = 5'd3;
    localparam logic [CodeWidth-1:0] KEY_HOME    = 5'd7;
    localparam logic [CodeWidth-1:0] KEY_END     = 5'd8;
    localparam logic [CodeWidth-1:0] KEY_PGUP    = 5'd9;
    localparam logic [CodeWidth-1:0] KEY_PGDN    = 5'd10;
    localparam logic [CodeWidth-1:0] KEY_TAB     = 5'd11;
    localparam logic [CodeWidth-1:0] KEY_BKSP    = 5'd12;
    localparam logic [CodeWidth-1:0] KEY_CTRL_Z  = 5'd13;
    localparam logic [CodeWidth-1:0] KEY_CTRL_A  = 5'd14;
    localparam logic [CodeWidth-1:0] KEY_CTRL_E  = 5'd15;
    localparam logic [CodeWidth-1:0] KEY_CTRL_C  = 5'd16;
    localparam logic [CodeWidth-1:0] KEY_CTRL_T  = 5'd17;
    localparam logic [CodeWidth-1:0] KEY_CTRL_U  = 5'd18;
    localparam logic [CodeWidth-1:0] KEY_CTRL_K  = 5'd19;
    localparam logic [CodeWidth-1:0] KEY_UNKNOWN = 5'd20;

    // received byte values
    localparam logic [ByteWidth-1:0] CHR_ESC    = 8'h1B;
    localparam logic [ByteWidth-1:0] CHR_CR     = 8'h0D;
    localparam logic [ByteWidth-1:0] CHR_TAB    = 8'h09;
    localparam logic [ByteWidth-1:0] CHR_DEL    = 8'h7F;
    localparam logic [ByteWidth-1:0] CHR_BS     = 8'h08;
    localparam logic [ByteWidth-1:0] CHR_TILDE  = 8'd126;
    localparam logic [ByteWidth-1:0] CHR_A      = 8'h41;
    localparam logic [ByteWidth-1:0] CHR_D      = 8'h44;
    localparam logic [ByteWidth-1:0] CHR_ZERO   = 8'h30;
    localparam logic [ByteWidth-1:0] CHR_ONE    = 8'h31;
    localparam logic [ByteWidth-1:0] CHR_SIX    = 8'h36;
    localparam logic [ByteWidth-1:0] CHR_SPACE  = 8'h20;
    localparam logic [ByteWidth-1:0] CHR_LAST   = 8'h7E;
    localparam logic [ByteWidth-1:0] CHR_CTRL_Z = 8'd26;
    localparam logic [ByteWidth-1:0] CHR_CTRL_A = 8'd1;
    localparam logic [ByteWidth-1:0] CHR_CTRL_E = 8'd5;
    localparam logic [ByteWidth-1:0] CHR_CTRL_C = 8'd3;
    localparam logic [ByteWidth-1:0] CHR_CTRL_T = 8'd20;
    localparam logic [ByteWidth-1:0] CHR_CTRL_U = 8'd21;
    localparam logic [ByteWidth-1:0] CHR_CTRL_K = 8'd11;

    localparam logic [DigitWidth-1:0] DIG_HOME = 3'd1;
    localparam logic [DigitWidth-1:0] DIG_END  = 3'd4;
    localparam logic [DigitWidth-1:0] DIG_PGUP = 3'd5;
    localparam logic [DigitWidth-1:0] DIG_PGDN = 3'd6;

    // input item action
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic                  action;
        logic [ByteWidth-1:0]  rx_byte;
    } tkd_item_t;

    typedef struct packed {
        logic                  valid;
        logic [CodeWidth-1:0]  key_code;
        logic [ByteWidth-1:0]  key_char;
    } tkd_result_t;

    function automatic logic [CodeWidth-1:0] single_key(input logic [ByteWidth-1:0] b);
        logic [CodeWidth-1:0] code;
        begin
            case (b)
                CHR_TAB:    code = KEY_TAB;
                CHR_DEL:    code = KEY_BKSP;
                CHR_BS:     code = KEY_BKSP;
                CHR_CTRL_Z: code = KEY_CTRL_Z;
                CHR_CTRL_A: code = KEY_CTRL_A;
                CHR_CTRL_E: code = KEY_CTRL_E;
                CHR_CTRL_C: code = KEY_CTRL_C;
                CHR_CTRL_T: code = KEY_CTRL_T;
                CHR_CTRL_U: code = KEY_CTRL_U;
                CHR_CTRL_K: code = KEY_CTRL_K;
                default:    code = KEY_UNKNOWN;
            endcase
            return code;
        end
    endfunction

endpackage

FILE: design/tkd_in_stage.sv
module tkd_in_stage
    import tkd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ByteWidth-1:0] s_tdata,   // [7:0] rx_byte
    input  logic                 s_tuser,   // [0] action
    input  logic                 advance,
    output tkd_item_t            item
);

    logic                 valid_reg, valid_next;
    logic                 action_reg;
    logic [ByteWidth-1:0] byte_reg;
    logic                 take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (take) begin
            action_reg <= s_tuser;
            byte_reg   <= s_tdata;
        end
    end

    assign item.valid   = valid_reg;
    assign item.action  = action_reg;
    assign item.rx_byte = byte_reg;

endmodule

FILE: design/tkd_decoder.sv
module tkd_decoder
    import tkd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [LimitWidth-1:0] cfg_wr_data,
    input  tkd_item_t             item,
    input  logic                  advance,
    output tkd_result_t           result
);

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_ESC1   = 5'b00010,
        MODE_ESC2   = 5'b00100,
        MODE_TILDE  = 5'b01000,
        MODE_CRSKIP = 5'b10000
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [LimitWidth-1:0] count_reg, count_next;
    logic [DigitWidth-1:0] digit_reg, digit_next;
    logic [LimitWidth-1:0] limit_reg;
    logic [LimitWidth-1:0] count_inc;
    logic                  fire;
    logic [ByteWidth-1:0]  b;

    assign fire      = item.valid && advance;
    assign b         = item.rx_byte;
    assign count_inc = count_reg + 1'b1;

    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        digit_next = digit_reg;
        result     = '0;
        if (fire) begin
            if (item.action == ACT_TICK) begin
                if (mode_reg != MODE_IDLE) begin
                    count_next = count_inc;
                    // a zero limit times out on the first tick as well
                    if (!(count_inc < limit_reg)) begin
                        mode_next  = MODE_IDLE;
                        count_next = '0;
                        digit_next = '0;
                        if (mode_reg == MODE_ESC1) begin
                            result.valid    = 1'b1;
                            result.key_code = KEY_ESC;
                        end else if (mode_reg != MODE_CRSKIP) begin
                            result.valid    = 1'b1;
                            result.key_code = KEY_UNKNOWN;
                        end
                    end
                end
            end else begin
                case (mode_reg)
                    MODE_ESC1: begin
                        // skip the bracket byte, whatever it is
                        mode_next  = MODE_ESC2;
                        count_next = '0;
                    end
                    MODE_ESC2: begin
                        count_next = '0;
                        if (b inside {[CHR_A:CHR_D]}) begin
                            mode_next       = MODE_IDLE;
                            digit_next      = '0;
                            result.valid    = 1'b1;
                            result.key_code = KEY_UP + CodeWidth'(b - CHR_A);
                        end else if (b inside {[CHR_ONE:CHR_SIX]}) begin
                            mode_next  = MODE_TILDE;
                            digit_next = DigitWidth'(b - CHR_ZERO);
                        end else begin
                            mode_next       = MODE_IDLE;
                            digit_next      = '0;
                            result.valid    = 1'b1;
                            result.key_code = KEY_UNKNOWN;
                        end
                    end
                    MODE_TILDE: begin
                        mode_next       = MODE_IDLE;
                        count_next      = '0;
                        digit_next      = '0;
                        result.valid    = 1'b1;
                        result.key_code = KEY_UNKNOWN;
                        if (b == CHR_TILDE) begin
                            case (digit_reg)
                                DIG_HOME: result.key_code = KEY_HOME;
                                DIG_END:  result.key_code = KEY_END;
                                DIG_PGUP: result.key_code = KEY_PGUP;
                                DIG_PGDN: result.key_code = KEY_PGDN;
                                default:  result.key_code = KEY_UNKNOWN;
                            endcase
                        end
                    end
                    MODE_CRSKIP: begin
                        // drop the byte after CR
                        mode_next  = MODE_IDLE;
                        count_next = '0;
                        digit_next = '0;
                    end
                    default: begin
                        mode_next  = MODE_IDLE;
                        count_next = '0;
                        digit_next = '0;
                        if (b inside {[CHR_SPACE:CHR_LAST]}) begin
                            result.valid    = 1'b1;
                            result.key_code = KEY_PRINT;
                            result.key_char = b;
                        end else if (b == CHR_ESC) begin
                            mode_next = MODE_ESC1;
                        end else if (b == CHR_CR) begin
                            mode_next       = MODE_CRSKIP;
                            result.valid    = 1'b1;
                            result.key_code = KEY_ENTER;
                        end else begin
                            result.valid    = 1'b1;
                            result.key_code = single_key(b);
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            digit_reg <= '0;
            limit_reg <= LimitReset;
        end else begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            digit_reg <= digit_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

endmodule

FILE: design/tkd_out_stage.sv
module tkd_out_stage
    import tkd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tkd_result_t result,
    output logic        advance,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [4:0] key_code, [12:5] key_char, [15:13] zero
);

    logic                 valid_reg, valid_next;
    logic [CodeWidth-1:0] code_reg;
    logic [ByteWidth-1:0] char_reg;
    logic                 load;

    // output register is free when empty or being taken now
    assign advance = !valid_reg || m_tready;
    assign load    = advance && result.valid;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg <= result.key_code;
            char_reg <= result.key_char;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, char_reg, code_reg};

endmodule

FILE: design/terminal_key_decoder_top.sv
// Requests pass from the input register through the parser into the result register behind m_tvalid.
// Throughput: one request per cycle unless m_tready holds a full result register; input and result
// registers each hold one item, and each request is decoded in a single pass through the parser.
// Reset (aresetn low, synchronous): pipeline emptied, parser idle, wait count and
// held digit cleared, wait limit back to 100000 ticks.
module terminal_key_decoder_top
    import tkd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [LimitWidth-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ByteWidth-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic                  s_tuser,   // [0] action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata    // [4:0] key_code, [12:5] key_char
);

    tkd_item_t   item;
    tkd_result_t result;
    logic        advance;

    tkd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .item     (item)
    );

    tkd_decoder u_dec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .advance     (advance),
        .result      (result)
    );

    tkd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // a character travels only with a printable key
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:0] != KEY_PRINT) |-> m_tdata[12:5] == '0)
        else $error("key_char set on a non-printable key");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[4:0] <= KEY_UNKNOWN)
        else $error("key_code out of range");

    // an empty result register must never stall the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a result register that fills must have been fed by an accepted request
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(!s_tready, 1)
            || $past(s_tvalid && s_tready, 3) || $past(m_tvalid, 2))
        else $error("result without a request");
`endif

endmodule

FILE: tb/testbench.sv
module testbench;
    import tkd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomBytesPerPhase = 60;
    localparam int NumPhases           = 6;
    localparam int SettleCycles        = 4;
    localparam int CycleLimit          = 400000;

    typedef enum logic [2:0] {
        PM_IDLE   = 3'd0,
        PM_ESC1   = 3'd1,
        PM_ESC2   = 3'd2,
        PM_TILDE  = 3'd3,
        PM_CRSKIP = 3'd4
    } parse_mode_t;

    typedef struct packed {
        logic [CodeWidth-1:0] code;
        logic [ByteWidth-1:0] ch;
    } key_t;

    typedef struct packed {
        logic                 act;
        logic [ByteWidth-1:0] b;
        bit                   typed;
        bit                   yields;
        logic [CodeWidth-1:0] code;
        logic [ByteWidth-1:0] ch;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [LimitWidth-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ByteWidth-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;

    // decoder copy kept alongside the block
    logic [LimitWidth-1:0] lim_model = LimitReset;
    parse_mode_t           pmode = PM_IDLE;
    logic [LimitWidth-1:0] wcount = '0;
    logic [DigitWidth-1:0] digit = '0;

    key_t pending_keys [$];

    // typed expectation of the directed row in flight
    bit                    row_typed = 1'b0;
    bit                    row_yields = 1'b0;
    key_t                  row_key = '0;

    int err_count = 0;
    int n_requests = 0;
    int n_keys = 0;
    int n_limits = 1;
    int cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;

    bit   has_key;
    key_t pred_key;
    key_t got_key;
    key_t exp_key;

    stim_row_t script [0:28] = '{
        '{ACT_TICK, 8'h00,      1'b1, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_SPACE,  1'b1, 1'b1, KEY_PRINT,   CHR_SPACE},
        '{ACT_BYTE, CHR_LAST,   1'b1, 1'b1, KEY_PRINT,   CHR_LAST},
        '{ACT_BYTE, 8'h00,      1'b1, 1'b1, KEY_UNKNOWN, 8'h00},
        '{ACT_BYTE, 8'hFF,      1'b1, 1'b1, KEY_UNKNOWN, 8'h00},
        '{ACT_BYTE, CHR_DEL,    1'b1, 1'b1, KEY_BKSP,    8'h00},
        '{ACT_BYTE, CHR_CR,     1'b1, 1'b1, KEY_ENTER,   8'h00},
        // byte after CR is swallowed, even an ESC
        '{ACT_BYTE, CHR_ESC,    1'b1, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_ESC,    1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, 8'h5B,      1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_A,      1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_ESC,    1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, 8'h4F,      1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_D,      1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_ESC,    1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, 8'h5B,      1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_ONE,    1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_TILDE,  1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_ESC,    1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, 8'h5B,      1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_SIX,    1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_TILDE,  1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_ESC,    1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, 8'h5B,      1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, 8'h5A,      1'b1, 1'b1, KEY_UNKNOWN, 8'h00},
        '{ACT_BYTE, CHR_ESC,    1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, 8'h5B,      1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, 8'h32,      1'b0, 1'b0, KEY_PRINT,   8'h00},
        '{ACT_BYTE, CHR_TILDE,  1'b1, 1'b1, KEY_UNKNOWN, 8'h00}
    };

    logic [LimitWidth-1:0] phase_limit [0:NumPhases-1] = '{
        20'd0, 20'd1, 20'd3, 20'hFFFFF, 20'd6, 20'd2
    };

    terminal_key_decoder_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void park_idle();
        pmode  = PM_IDLE;
        wcount = '0;
        digit  = '0;
    endfunction

    // advance the decoder copy by one request
    function automatic void decode_request(input logic act, input logic [ByteWidth-1:0] b,
                                           output bit yields, output key_t k);
        parse_mode_t cur;
        cur    = pmode;
        yields = 1'b0;
        k      = '0;
        if (act == ACT_TICK) begin
            if (cur == PM_IDLE)
                return;
            wcount = wcount + 1'b1;
            if (wcount < lim_model)
                return;
            park_idle();
            if (cur == PM_ESC1) begin
                yields = 1'b1;
                k.code = KEY_ESC;
            end else if (cur != PM_CRSKIP) begin
                yields = 1'b1;
                k.code = KEY_UNKNOWN;
            end
            return;
        end
        case (cur)
            PM_ESC1: begin
                pmode  = PM_ESC2;
                wcount = '0;
                return;
            end
            PM_ESC2: begin
                if (b >= CHR_A && b <= CHR_D) begin
                    park_idle();
                    yields = 1'b1;
                    k.code = KEY_UP + CodeWidth'(b - CHR_A);
                end else if (b >= CHR_ONE && b <= CHR_SIX) begin
                    digit  = DigitWidth'(b - CHR_ZERO);
                    pmode  = PM_TILDE;
                    wcount = '0;
                end else begin
                    park_idle();
                    yields = 1'b1;
                    k.code = KEY_UNKNOWN;
                end
                return;
            end
            PM_TILDE: begin
                yields = 1'b1;
                k.code = KEY_UNKNOWN;
                if (b == CHR_TILDE) begin
                    if (digit == DIG_HOME)
                        k.code = KEY_HOME;
                    else if (digit == DIG_END)
                        k.code = KEY_END;
                    else if (digit == DIG_PGUP)
                        k.code = KEY_PGUP;
                    else if (digit == DIG_PGDN)
                        k.code = KEY_PGDN;
                end
                park_idle();
                return;
            end
            PM_CRSKIP: begin
                park_idle();
                return;
            end
            default: begin
            end
        endcase
        yields = 1'b1;
        if (b >= CHR_SPACE && b <= CHR_LAST) begin
            k.code = KEY_PRINT;
            k.ch   = b;
        end else if (b == CHR_ESC) begin
            yields = 1'b0;
            pmode  = PM_ESC1;
            wcount = '0;
        end else if (b == CHR_CR) begin
            pmode  = PM_CRSKIP;
            wcount = '0;
            k.code = KEY_ENTER;
        end else begin
            case (b)
                CHR_TAB:           k.code = KEY_TAB;
                CHR_DEL, CHR_BS:   k.code = KEY_BKSP;
                CHR_CTRL_Z:        k.code = KEY_CTRL_Z;
                CHR_CTRL_A:        k.code = KEY_CTRL_A;
                CHR_CTRL_E:        k.code = KEY_CTRL_E;
                CHR_CTRL_C:        k.code = KEY_CTRL_C;
                CHR_CTRL_T:        k.code = KEY_CTRL_T;
                CHR_CTRL_U:        k.code = KEY_CTRL_U;
                CHR_CTRL_K:        k.code = KEY_CTRL_K;
                default:           k.code = KEY_UNKNOWN;
            endcase
        end
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("MISMATCH at %0t: %s, expected %0d, got %0d", $realtime, what, exp_v, got_v);
        err_count++;
    endtask

    // request side predicts, key side checks
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                decode_request(s_tuser, s_tdata, has_key, pred_key);
                if (row_typed) begin
                    has_key  = row_yields;
                    pred_key = row_key;
                end
                if (has_key)
                    pending_keys.push_back(pred_key);
                n_requests++;
            end
            if (m_tvalid && m_tready) begin
                got_key.code = m_tdata[4:0];
                got_key.ch   = m_tdata[12:5];
                n_keys++;
                if (pending_keys.size() == 0) begin
                    report_mismatch("key with none pending, code", -1, got_key.code);
                end else begin
                    exp_key = pending_keys.pop_front();
                    if (got_key.code !== exp_key.code)
                        report_mismatch("key_code", exp_key.code, got_key.code);
                    if (got_key.ch !== exp_key.ch)
                        report_mismatch("key_char", exp_key.ch, got_key.ch);
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles, %0d keys still pending", cycles,
                     pending_keys.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // entered and left at a falling edge
    task automatic send_item(input logic act, input logic [ByteWidth-1:0] b, input bit typed,
                             input bit yields, input key_t k);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= act;
        s_tdata    <= b;
        row_typed  <= typed;
        row_yields <= yields;
        row_key    <= k;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [ByteWidth-1:0] b);
        send_item(ACT_BYTE, b, 1'b0, 1'b0, '0);
        bytes_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(ACT_TICK, ByteWidth'($urandom_range(255)), 1'b0, 1'b0, '0);
    endtask

    // hold requests until every pending key has come out
    task automatic drain_keys();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_keys.size() != 0);
    endtask

    task automatic write_limit(input logic [LimitWidth-1:0] v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        lim_model   = v;
    endtask

    function automatic int ticks_to_timeout();
        return (lim_model == 0) ? 1 : int'(lim_model);
    endfunction

    // a few ticks inside a sequence, sometimes enough to time it out
    task automatic maybe_ticks();
        if (ticks_to_timeout() <= 16 && $urandom_range(3) == 0)
            send_ticks($urandom_range(1, ticks_to_timeout()));
    endtask

    function automatic logic [ByteWidth-1:0] any_key_byte();
        logic [ByteWidth-1:0] mapped [0:9];
        mapped = '{CHR_TAB, CHR_DEL, CHR_BS, CHR_CTRL_Z, CHR_CTRL_A, CHR_CTRL_E,
                   CHR_CTRL_C, CHR_CTRL_T, CHR_CTRL_U, CHR_CTRL_K};
        case ($urandom_range(2))
            0:       return ByteWidth'($urandom_range(CHR_SPACE, CHR_LAST));
            1:       return mapped[$urandom_range(9)];
            default: return ByteWidth'($urandom_range(255));
        endcase
    endfunction

    task automatic run_random(input int n_bytes);
        int  pick;
        int  stop_at;
        bit  paused;
        stop_at    = bytes_sent + n_bytes;
        paused     = 1'b0;
        while (bytes_sent < stop_at) begin
            if (!paused && bytes_sent >= stop_at - n_bytes / 2) begin
                paused = 1'b1;
                drain_keys();
            end
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_byte(CHR_ESC);
                maybe_ticks();
                send_byte($urandom_range(1) ? 8'h5B : ByteWidth'($urandom_range(255)));
                maybe_ticks();
                case ($urandom_range(9))
                    0, 1, 2, 3: send_byte(CHR_A + ByteWidth'($urandom_range(3)));
                    4, 5, 6, 7: begin
                        send_byte(CHR_ONE + ByteWidth'($urandom_range(5)));
                        maybe_ticks();
                        send_byte($urandom_range(6) == 0 ? ByteWidth'($urandom_range(255))
                                                         : CHR_TILDE);
                    end
                    default:    send_byte(ByteWidth'($urandom_range(255)));
                endcase
            end else if (pick < 45) begin
                send_byte(CHR_ESC);
                if (ticks_to_timeout() <= 16)
                    send_ticks(ticks_to_timeout());
                else
                    send_byte(ByteWidth'($urandom_range(255)));
            end else if (pick < 55) begin
                send_byte(CHR_CR);
                if (ticks_to_timeout() <= 16 && $urandom_range(1))
                    send_ticks(ticks_to_timeout());
                send_byte(any_key_byte());
            end else if (pick < 85) begin
                send_byte(any_key_byte());
            end else begin
                send_ticks($urandom_range(1, 3));
            end
        end
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed rows at the reset limit, no idling
        foreach (script[i])
            send_item(script[i].act, script[i].b, script[i].typed, script[i].yields,
                      '{script[i].code, script[i].ch});

        phase_limit[NumPhases-1] = LimitWidth'($urandom_range(1, 12));
        for (int ph = 0; ph < NumPhases; ph++) begin
            drain_keys();
            repeat (SettleCycles) @(negedge aclk);
            write_limit(phase_limit[ph]);
            n_limits++;
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase
            run_random(RandomBytesPerPhase);
        end

        drain_keys();
        repeat (SettleCycles * 2) @(negedge aclk);
        if (pending_keys.size() != 0)
            report_mismatch("keys never delivered", 0, pending_keys.size());

        $display("Run covered %0d requests and %0d decoded keys under %0d wait limits,",
                 n_requests, n_keys, n_limits);
        $display("from zero and one up to the 20-bit maximum, with idling on either side.");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
